// ----- rtl/core/y2p_pkg.sv -----
// Shared types, widths and constants for the packed 4:2:2 to planar 4:2:0 converter.
`timescale 1ns / 1ps

package y2p_pkg;

	localparam int REG_W     = 11;
	localparam int ADDR_W    = 23;
	localparam int LUMA_W    = 22;
	localparam int BASE_W    = 20;
	localparam int ROW_W     = 11;
	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = 2 * REG_W;

	localparam int MAX_PAIRS_DEF = 1024;

	localparam logic [REG_W-1:0] PIXEL_PAIRS_RST = REG_W'(176);
	localparam logic [REG_W-1:0] ROW_PAIRS_RST   = REG_W'(144);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_PAIRS = 2'd0,
		REG_ROW_PAIRS   = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PLANE_Y = 2'd0,
		PLANE_U = 2'd1,
		PLANE_V = 2'd2
	} plane_t;

	typedef struct packed {
		plane_t                  plane;
		logic [ADDR_W-1:0]       offset;
		logic [BYTE_W-1:0]       value;
	} item_t;

endpackage

// ----- rtl/core/y2p_cfg_regs.sv -----
// Configuration registers, clamped frame dimensions and the registered plane size.
`timescale 1ns / 1ps

module y2p_cfg_regs #(
	parameter int MAX_PAIRS = y2p_pkg::MAX_PAIRS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [y2p_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [y2p_pkg::REG_W-1:0]      cfg_data,
	output logic [y2p_pkg::REG_W-1:0]      eff_pp,
	output logic [y2p_pkg::REG_W-1:0]      eff_rp,
	output logic [y2p_pkg::PROD_W-1:0]     plane_size_q
);
	import y2p_pkg::*;

	logic [REG_W-1:0] pixel_pairs_q;
	logic [REG_W-1:0] row_pairs_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_pairs_q <= PIXEL_PAIRS_RST;
			row_pairs_q   <= ROW_PAIRS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PIXEL_PAIRS: pixel_pairs_q <= cfg_data;
				REG_ROW_PAIRS:   row_pairs_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// A zero register acts as one, a register above the limit acts as the limit.
	always_comb begin
		if (pixel_pairs_q == '0) begin
			eff_pp = REG_W'(1);
		end else if (32'(pixel_pairs_q) > MAX_PAIRS) begin
			eff_pp = REG_W'(MAX_PAIRS);
		end else begin
			eff_pp = pixel_pairs_q;
		end
		if (row_pairs_q == '0) begin
			eff_rp = REG_W'(1);
		end else if (32'(row_pairs_q) > MAX_PAIRS) begin
			eff_rp = REG_W'(MAX_PAIRS);
		end else begin
			eff_rp = row_pairs_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_size_q <= PROD_W'(PIXEL_PAIRS_RST) * PROD_W'(ROW_PAIRS_RST);
		end else begin
			plane_size_q <= PROD_W'(eff_pp) * PROD_W'(eff_rp);
		end
	end

endmodule

// ----- rtl/core/y2p_pos_tracker.sv -----
// Frame position counters that classify each incoming byte and give its plane offset.
`timescale 1ns / 1ps

module y2p_pos_tracker #(
	parameter int MAX_PAIRS = y2p_pkg::MAX_PAIRS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [y2p_pkg::BYTE_W-1:0]  pixel_byte,
	input  logic [y2p_pkg::REG_W-1:0]   eff_pp,
	input  logic [y2p_pkg::REG_W-1:0]   eff_rp,
	output logic                        keep,
	output y2p_pkg::item_t              item
);
	import y2p_pkg::*;

	localparam int PAIR_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int CMP_W  = (PAIR_W > REG_W) ? PAIR_W : REG_W;

	typedef enum logic [1:0] {
		PH_Y0 = 2'd0,
		PH_U  = 2'd1,
		PH_Y1 = 2'd2,
		PH_V  = 2'd3
	} phase_t;

	phase_t              phase_q;
	logic [PAIR_W-1:0]   pair_col_q;
	logic [ROW_W-1:0]    row_q;
	logic [LUMA_W-1:0]   luma_q;
	logic [BASE_W-1:0]   base_q;

	logic                odd_row;
	logic                row_end;
	logic                frame_end;
	logic [ROW_W:0]      row_last;
	logic [ADDR_W-1:0]   chroma_off;

	assign odd_row    = row_q[0];
	assign row_end    = CMP_W'(pair_col_q) >= (CMP_W'(eff_pp) - CMP_W'(1));
	assign row_last   = {eff_rp, 1'b0} - (ROW_W+1)'(1);
	assign frame_end  = {1'b0, row_q} >= row_last;
	assign chroma_off = ADDR_W'(base_q) + ADDR_W'(pair_col_q);

	always_comb begin
		item.value  = pixel_byte;
		item.plane  = PLANE_Y;
		item.offset = ADDR_W'(luma_q);
		keep        = 1'b0;
		case (phase_q)
			PH_Y0, PH_Y1: begin
				keep = 1'b1;
			end
			PH_U: begin
				keep        = !odd_row;
				item.plane  = PLANE_U;
				item.offset = chroma_off;
			end
			PH_V: begin
				keep        = odd_row;
				item.plane  = PLANE_V;
				item.offset = chroma_off;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_Y0;
			pair_col_q <= '0;
			row_q      <= '0;
			luma_q     <= '0;
			base_q     <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_Y0: begin
					phase_q <= PH_U;
					luma_q  <= luma_q + LUMA_W'(1);
				end
				PH_U: begin
					phase_q <= PH_Y1;
				end
				PH_Y1: begin
					phase_q <= PH_V;
					luma_q  <= luma_q + LUMA_W'(1);
				end
				PH_V: begin
					phase_q <= PH_Y0;
					if (row_end) begin
						pair_col_q <= '0;
						if (frame_end) begin
							row_q  <= '0;
							base_q <= '0;
							luma_q <= '0;
						end else begin
							if (odd_row) begin
								base_q <= base_q + BASE_W'(eff_pp);
							end
							row_q <= row_q + ROW_W'(1);
						end
					end else begin
						pair_col_q <= pair_col_q + PAIR_W'(1);
					end
				end
				default: phase_q <= PH_Y0;
			endcase
		end
	end

`ifndef SYNTH
	a_col_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q != PH_V) |=> (pair_col_q == $past(pair_col_q)))
		else $error("pair column moved inside a pixel pair");
	a_luma_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_Y0) |=> (luma_q == $past(luma_q) + LUMA_W'(1)))
		else $error("luma address did not advance after first luma byte");
	a_luma_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_Y0 || phase_q == PH_Y1) |-> (keep && item.plane == PLANE_Y))
		else $error("luma byte not routed to the luma plane");
`endif

endmodule

// ----- rtl/core/y2p_addr_stage.sv -----
// Input register and result register that add the plane start to each kept byte's offset.
`timescale 1ns / 1ps

module y2p_addr_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         keep,
	input  y2p_pkg::item_t               item,
	input  logic [y2p_pkg::PROD_W-1:0]   plane_size_q,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [y2p_pkg::ADDR_W-1:0]   out_address,
	output logic [y2p_pkg::BYTE_W-1:0]   out_value,
	output logic [1:0]                   out_plane
);
	import y2p_pkg::*;

	localparam int SUM_W = PROD_W + 3;

	item_t              item_s1;
	logic               valid_s1;
	logic               valid_s2;
	logic [ADDR_W-1:0]  address_s2;
	logic [BYTE_W-1:0]  value_s2;
	plane_t             plane_s2;

	logic               adv_s1;
	logic [SUM_W-1:0]   luma_size;
	logic [SUM_W-1:0]   plane_start;
	logic [ADDR_W-1:0]  address_d;

	assign adv_s1   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s1;

	assign luma_size = {SUM_W'(plane_size_q)} << 2;

	always_comb begin
		case (item_s1.plane)
			PLANE_U: plane_start = luma_size;
			PLANE_V: plane_start = luma_size + SUM_W'(plane_size_q);
			default: plane_start = '0;
		endcase
	end

	assign address_d = ADDR_W'(plane_start) + item_s1.offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid && keep;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid && keep) begin
			item_s1 <= item;
		end
		if (adv_s1 && valid_s1) begin
			address_s2 <= address_d;
			value_s2   <= item_s1.value;
			plane_s2   <= item_s1.plane;
		end
	end

	assign out_valid   = valid_s2;
	assign out_address = address_s2;
	assign out_value   = value_s2;
	assign out_plane   = plane_s2;

`ifndef SYNTH
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled byte lost from the input register");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && valid_s1) |-> adv_s1)
		else $error("input taken while the input register cannot drain");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_address)
			&& $stable(out_value) && $stable(out_plane)))
		else $error("stalled result changed before its transfer");
`endif

endmodule

// ----- rtl/core/yuyv_to_planar_420_converter.sv -----
// A kept byte moves through the input register and then the result register to the result port.
// Throughput: one byte per cycle while the result port is not stalled.
// The input and result registers form the two stages; bytes that carry no result leave no trace.
// The configuration port always accepts; the plane size is registered from the clamped values.
// Reset clears the position counters and valid flags and loads 176 pixel pairs by 144 row pairs.
`timescale 1ns / 1ps

module yuyv_to_planar_420_converter #(
	parameter int MAX_PAIRS = y2p_pkg::MAX_PAIRS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [y2p_pkg::BYTE_W-1:0]     pixel_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [y2p_pkg::ADDR_W-1:0]     out_address,
	output logic [y2p_pkg::BYTE_W-1:0]     out_value,
	output logic [1:0]                     out_plane,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [y2p_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [y2p_pkg::REG_W-1:0]      cfg_data
);
	import y2p_pkg::*;

	logic [REG_W-1:0]  eff_pp;
	logic [REG_W-1:0]  eff_rp;
	logic [PROD_W-1:0] plane_size_q;
	logic              keep;
	item_t             item;

	y2p_cfg_regs #(
		.MAX_PAIRS(MAX_PAIRS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.eff_pp      (eff_pp),
		.eff_rp      (eff_rp),
		.plane_size_q(plane_size_q)
	);

	y2p_pos_tracker #(
		.MAX_PAIRS(MAX_PAIRS)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_valid && in_ready),
		.pixel_byte(pixel_byte),
		.eff_pp    (eff_pp),
		.eff_rp    (eff_rp),
		.keep      (keep),
		.item      (item)
	);

	y2p_addr_stage u_addr (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.keep        (keep),
		.item        (item),
		.plane_size_q(plane_size_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_address (out_address),
		.out_value   (out_value),
		.out_plane   (out_plane)
	);

endmodule

// ----- tb/yuyv_to_planar_420_converter_tb.sv -----
// Self-checking testbench for the packed 4:2:2 to planar 4:2:0 address converter.
`timescale 1ns / 1ps

module yuyv_to_planar_420_converter_tb;
	import y2p_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int PAIR_LIMIT = MAX_PAIRS_DEF;
	localparam int PIPE_FLUSH = 6;
	localparam int RUN_LIMIT_NS = 5_000_000;

	localparam logic [1:0] PHASE_Y0 = 2'd0;
	localparam logic [1:0] PHASE_U  = 2'd1;
	localparam logic [1:0] PHASE_Y1 = 2'd2;
	localparam logic [1:0] PHASE_V  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    pixel_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [ADDR_W-1:0]    out_address;
	logic [BYTE_W-1:0]    out_value;
	logic [1:0]           out_plane;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_data = '0;

	int unsigned send_idle_pct = 17;
	int unsigned recv_stall_pct = 70;
	int          error_count = 0;

	item_t pending_writes[$];

	logic [REG_W-1:0]  reg_pixel_pairs = PIXEL_PAIRS_RST;
	logic [REG_W-1:0]  reg_row_pairs = ROW_PAIRS_RST;
	logic [1:0]        cur_phase = PHASE_Y0;
	logic [9:0]        cur_col = '0;
	logic [ROW_W-1:0]  cur_row = '0;
	logic [LUMA_W-1:0] cur_luma = '0;
	logic [BASE_W-1:0] cur_chroma_base = '0;

	yuyv_to_planar_420_converter u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_byte  (pixel_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_address (out_address),
		.out_value   (out_value),
		.out_plane   (out_plane),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic int unsigned usable_pairs(input logic [REG_W-1:0] r);
		if (r == '0)
			return 1;
		if (r > PAIR_LIMIT)
			return PAIR_LIMIT;
		return r;
	endfunction

	// Predicts where a kept byte lands in the planar buffer; advances the position for any byte.
	task automatic predict_planar_write(input logic [BYTE_W-1:0] b);
		int unsigned pp;
		int unsigned rp;
		int unsigned luma_size;
		int unsigned chroma_size;
		logic        odd_row;
		item_t       w;
		pp = usable_pairs(reg_pixel_pairs);
		rp = usable_pairs(reg_row_pairs);
		luma_size = 4 * pp * rp;
		chroma_size = pp * rp;
		odd_row = cur_row[0];
		w.value = b;
		case (cur_phase)
			PHASE_Y0, PHASE_Y1: begin
				w.plane = PLANE_Y;
				w.offset = ADDR_W'(cur_luma);
				pending_writes.push_back(w);
				cur_luma = cur_luma + 1'b1;
			end
			PHASE_U: begin
				if (!odd_row) begin
					w.plane = PLANE_U;
					w.offset = ADDR_W'(luma_size + cur_chroma_base + cur_col);
					pending_writes.push_back(w);
				end
			end
			default: begin
				if (odd_row) begin
					w.plane = PLANE_V;
					w.offset = ADDR_W'(luma_size + chroma_size + cur_chroma_base + cur_col);
					pending_writes.push_back(w);
				end
			end
		endcase
		if (cur_phase == PHASE_V) begin
			cur_phase = PHASE_Y0;
			if (cur_col >= pp - 1) begin
				cur_col = '0;
				if (cur_row >= 2 * rp - 1) begin
					cur_row = '0;
					cur_chroma_base = '0;
					cur_luma = '0;
				end else begin
					if (odd_row)
						cur_chroma_base = BASE_W'(cur_chroma_base + pp);
					cur_row = cur_row + 1'b1;
				end
			end else begin
				cur_col = cur_col + 1'b1;
			end
		end else begin
			cur_phase = cur_phase + 1'b1;
		end
	endtask

	always @(posedge clk) begin : result_check
		item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_writes.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result: expected none, actual addr %0h value %0h plane %0d",
					$time, out_address, out_value, out_plane);
			end else begin
				want = pending_writes.pop_front();
				if (out_address !== want.offset) begin
					error_count++;
					$display("%0t: out_address mismatch: expected %0h actual %0h",
						$time, want.offset, out_address);
				end
				if (out_value !== want.value) begin
					error_count++;
					$display("%0t: out_value mismatch: expected %0h actual %0h",
						$time, want.value, out_value);
				end
				if (out_plane !== want.plane) begin
					error_count++;
					$display("%0t: out_plane mismatch: expected %0d actual %0d",
						$time, want.plane, out_plane);
				end
			end
		end
	end

	// Valid is only lowered ahead of a gap, so back-to-back transfers keep it high.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		pixel_byte <= b;
		do @(posedge clk); while (!in_ready);
		predict_planar_write(b);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PIXEL_PAIRS: reg_pixel_pairs = data;
			REG_ROW_PAIRS:   reg_row_pairs = data;
			default: ;
		endcase
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (PIPE_FLUSH) @(posedge clk);
	endtask

	task automatic configure(input bit set_pp, input logic [REG_W-1:0] pp,
			input bit set_rp, input logic [REG_W-1:0] rp, input bit poke_unused);
		drain();
		if (set_pp)
			write_reg(REG_PIXEL_PAIRS, pp);
		if (set_rp)
			write_reg(REG_ROW_PAIRS, rp);
		if (poke_unused) begin
			write_reg(REG_UNUSED_LO, REG_W'($urandom));
			write_reg(REG_UNUSED_HI, REG_W'($urandom));
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_geometry;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(BYTE_W'($urandom));
		send_byte(BYTE_W'($urandom));
	endtask

	task automatic test_pair_extremes;
		configure(1'b1, 11'h7FF, 1'b1, 11'h000, 1'b0);
		repeat (4) send_byte(BYTE_W'($urandom));
		configure(1'b1, 11'h000, 1'b1, 11'h7FF, 1'b0);
		repeat (4) send_byte(BYTE_W'($urandom));
	endtask

	// A one by one pair frame is eight bytes: even row keeps U, odd row keeps V, then it wraps.
	task automatic test_frame_wrap;
		configure(1'b1, 11'd1, 1'b1, 11'd1, 1'b0);
		send_byte(8'hFF);
		repeat (6) send_byte(BYTE_W'($urandom));
		send_byte(8'h00);
	endtask

	task automatic test_ignored_index;
		drain();
		write_reg(REG_UNUSED_LO, 11'h7FF);
		write_reg(REG_UNUSED_HI, 11'h000);
		cfg_valid <= 1'b0;
		repeat (4) send_byte(BYTE_W'($urandom));
	endtask

	task automatic test_random_stream(input int n_items, input int unsigned idle_pct,
			input int unsigned stall_pct);
		int               sent;
		int               chunk;
		int               pick;
		logic [REG_W-1:0] pp;
		logic [REG_W-1:0] rp;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			if (sent == 0 || $urandom_range(2) == 0) begin
				pp = REG_W'($urandom_range(1, 4));
				rp = REG_W'($urandom_range(1, 3));
				if ($urandom_range(11) == 0) begin
					case ($urandom_range(3))
						0: pp = '0;
						1: pp = REG_W'(PAIR_LIMIT);
						2: pp = REG_W'($urandom_range(PAIR_LIMIT + 1, 2047));
						default: pp = REG_W'($urandom_range(5, PAIR_LIMIT - 1));
					endcase
				end
				if ($urandom_range(11) == 0) begin
					case ($urandom_range(3))
						0: rp = '0;
						1: rp = REG_W'(PAIR_LIMIT);
						2: rp = REG_W'($urandom_range(PAIR_LIMIT + 1, 2047));
						default: rp = REG_W'($urandom_range(4, PAIR_LIMIT - 1));
					endcase
				end
				pick = $urandom_range(3);
				configure(pick != 2, pp, pick != 1, rp, pick == 3);
			end
			chunk = $urandom_range(16, 64);
			repeat (chunk) send_byte(BYTE_W'($urandom));
			sent += chunk;
		end
	endtask

	initial begin
		#(RUN_LIMIT_NS);
		$display("yuyv_to_planar_420_converter regression: fail");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_pair_extremes();
		test_frame_wrap();
		test_ignored_index();
		test_random_stream(260, 17, 70);
		test_random_stream(260, 70, 17);
		test_random_stream(260, 0, 0);
		drain();
		if (error_count == 0 && pending_writes.size() == 0) begin
			$display("yuyv_to_planar_420_converter regression: pass");
		end else begin
			$display("yuyv_to_planar_420_converter regression: fail");
		end
		$finish;
	end

endmodule
